/* src/psit_pkg.sv */
`timescale 1ns / 1ps

package psit_pkg;

    // Fraction bits of every vector component.
    localparam int FRAC_BITS = 30;

    // One root bit per stage over a 66-bit radicand.
    localparam int SQRT_STEPS = 33;
    // One quotient bit per stage; a unit quotient needs FRAC_BITS + 1 bits.
    localparam int DIV_STEPS = FRAC_BITS + 1;
    // Magnitude, square, sum, root, divide and output stages.
    localparam int NORM_LAT = 4 + SQRT_STEPS + DIV_STEPS;
    // Difference stage, two normalizers, two cross stages, two dot stages.
    localparam int EDGE_LAT = 2 * NORM_LAT + 5;
    // Delay of the first corner from the difference stage to the dot stage.
    localparam int F_DLY = 2 * NORM_LAT + 3;

    localparam logic [29:0] TOL_RESET = 30'd8;

    typedef enum logic {
        CFG_EPS = 1'b0,
        CFG_TOL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec32;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_vec33;

endpackage

/* src/psit_if.sv */
`timescale 1ns / 1ps

interface psit_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic signed [31:0] p_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    p_x, p_y, p_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  p_x, p_y, p_z, output ready);
endinterface

interface psit_out_if;
    logic       valid;
    logic       ready;
    logic       inside_res;
    logic [2:0] edge_pass;

    modport source (output valid, inside_res, edge_pass, input ready);
    modport sink (input valid, inside_res, edge_pass, output ready);
endinterface

/* src/psit_norm.sv */
`timescale 1ns / 1ps

module psit_norm (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [29:0]      i_tol,
    input  psit_pkg::t_vec33 i_w,
    output psit_pkg::t_vec32 o_w
);

    localparam int SIDE_N = psit_pkg::SQRT_STEPS + psit_pkg::DIV_STEPS;

    typedef struct packed {
        logic             skip;
        logic [2:0]       sgn;
        logic [2:0][31:0] mag;
    } t_nside;

    logic signed [32:0] w_in [3];
    assign w_in[0] = i_w.x;
    assign w_in[1] = i_w.y;
    assign w_in[2] = i_w.z;

    t_nside      r1_side;
    logic [63:0] r2_sq [3];
    t_nside      r2_side;
    logic [65:0] r3_s;
    t_nside      r3_side;

    logic [36:0] r_sq_rem  [psit_pkg::SQRT_STEPS];
    logic [32:0] r_sq_root [psit_pkg::SQRT_STEPS];
    logic [65:0] r_sq_rad  [psit_pkg::SQRT_STEPS];
    logic [36:0] n_sq_rem  [psit_pkg::SQRT_STEPS];
    logic [32:0] n_sq_root [psit_pkg::SQRT_STEPS];
    logic [65:0] n_sq_rad  [psit_pkg::SQRT_STEPS];

    logic [33:0] r_dv_rem [psit_pkg::DIV_STEPS][3];
    logic [30:0] r_dv_q   [psit_pkg::DIV_STEPS][3];
    logic [32:0] r_dv_d   [psit_pkg::DIV_STEPS];
    logic [33:0] n_dv_rem [psit_pkg::DIV_STEPS][3];
    logic [30:0] n_dv_q   [psit_pkg::DIV_STEPS][3];
    logic [32:0] n_dv_d   [psit_pkg::DIV_STEPS];

    t_nside r_side [SIDE_N];

    psit_pkg::t_vec32 r_out;
    logic [31:0]      out_val [3];
    logic [31:0]      out_sgn [3];

    // Digit-by-digit square root, two radicand bits per stage.
    always_comb begin
        logic [36:0] rem_i;
        logic [36:0] sh;
        logic [36:0] trial;
        logic [32:0] root_i;
        logic [65:0] rad_i;
        for (int k = 0; k < psit_pkg::SQRT_STEPS; k++) begin
            if (k == 0) begin
                rem_i  = '0;
                root_i = '0;
                rad_i  = r3_s;
            end else begin
                rem_i  = r_sq_rem[k - 1];
                root_i = r_sq_root[k - 1];
                rad_i  = r_sq_rad[k - 1];
            end
            sh    = {rem_i[34:0], rad_i[65:64]};
            trial = {2'b00, root_i, 2'b01};
            if (sh >= trial) begin
                n_sq_rem[k]  = sh - trial;
                n_sq_root[k] = {root_i[31:0], 1'b1};
            end else begin
                n_sq_rem[k]  = sh;
                n_sq_root[k] = {root_i[31:0], 1'b0};
            end
            n_sq_rad[k] = {rad_i[63:0], 2'b00};
        end
    end

    // Restoring division of mag * 2^FRAC_BITS by the root, one bit per stage.
    // The quotient never exceeds 2^FRAC_BITS since no component exceeds the root.
    always_comb begin
        logic [33:0] rem_i;
        logic [33:0] sh;
        logic [30:0] q_i;
        logic [32:0] d_i;
        logic        nb;
        t_nside      sd;
        for (int j = 0; j < psit_pkg::DIV_STEPS; j++) begin
            if (j == 0) begin
                d_i = r_sq_root[psit_pkg::SQRT_STEPS - 1];
                sd  = r_side[psit_pkg::SQRT_STEPS - 1];
            end else begin
                d_i = r_dv_d[j - 1];
                sd  = r_side[0];
            end
            n_dv_d[j] = d_i;
            for (int c = 0; c < 3; c++) begin
                if (j == 0) begin
                    rem_i = {3'b000, sd.mag[c][31:1]};
                    q_i   = '0;
                    nb    = sd.mag[c][0];
                end else begin
                    rem_i = r_dv_rem[j - 1][c];
                    q_i   = r_dv_q[j - 1][c];
                    nb    = 1'b0;
                end
                sh = {rem_i[32:0], nb};
                if (sh >= {1'b0, d_i}) begin
                    n_dv_rem[j][c] = sh - {1'b0, d_i};
                    n_dv_q[j][c]   = {q_i[29:0], 1'b1};
                end else begin
                    n_dv_rem[j][c] = sh;
                    n_dv_q[j][c]   = {q_i[29:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        t_nside sd;
        sd = r_side[SIDE_N - 1];
        for (int c = 0; c < 3; c++) begin
            out_val[c] = sd.skip ? sd.mag[c]
                                 : {1'b0, r_dv_q[psit_pkg::DIV_STEPS - 1][c]};
            out_sgn[c] = sd.sgn[c] ? (32'd0 - out_val[c]) : out_val[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r1_side.sgn[c] <= w_in[c][32];
                r1_side.mag[c] <= w_in[c][32] ? 32'(-w_in[c]) : 32'(w_in[c]);
                r2_sq[c]       <= 64'(r1_side.mag[c]) * 64'(r1_side.mag[c]);
            end
            r1_side.skip <= 1'b0;
            r2_side      <= r1_side;

            r3_s         <= 66'(r2_sq[0]) + 66'(r2_sq[1]) + 66'(r2_sq[2]);
            r3_side.sgn  <= r2_side.sgn;
            r3_side.mag  <= r2_side.mag;
            r3_side.skip <= (66'(r2_sq[0]) + 66'(r2_sq[1]) + 66'(r2_sq[2]))
                            <= (66'(i_tol) << psit_pkg::FRAC_BITS);

            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
            r_sq_rad  <= n_sq_rad;
            r_dv_rem  <= n_dv_rem;
            r_dv_q    <= n_dv_q;
            r_dv_d    <= n_dv_d;

            r_side[0] <= r3_side;
            for (int i = 1; i < SIDE_N; i++) begin
                r_side[i] <= r_side[i - 1];
            end

            r_out.x <= out_sgn[0];
            r_out.y <= out_sgn[1];
            r_out.z <= out_sgn[2];
        end
    end

    assign o_w = r_out;

endmodule

/* src/psit_edge.sv */
`timescale 1ns / 1ps

module psit_edge (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [30:0] i_eps,
    input  logic [29:0]        i_tol,
    input  psit_pkg::t_vec32   i_f,
    input  psit_pkg::t_vec32   i_s,
    input  psit_pkg::t_vec32   i_p,
    output logic               o_pass
);

    psit_pkg::t_vec33 r_u;
    psit_pkg::t_vec33 r_v;
    psit_pkg::t_vec32 r_fd [psit_pkg::F_DLY];
    psit_pkg::t_vec32 nu;
    psit_pkg::t_vec32 nv;
    psit_pkg::t_vec33 r_n;
    psit_pkg::t_vec32 nn;
    logic signed [63:0] r_cp [6];
    logic signed [63:0] r_dp [3];
    logic signed [32:0] n_cr [3];
    logic signed [65:0] dot_sum;
    logic               r_pass;

    psit_norm u_norm_u (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_tol (i_tol),
        .i_w   (r_u),
        .o_w   (nu)
    );

    psit_norm u_norm_v (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_tol (i_tol),
        .i_w   (r_v),
        .o_w   (nv)
    );

    psit_norm u_norm_n (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_tol (i_tol),
        .i_w   (r_n),
        .o_w   (nn)
    );

    // Differences of products scaled down, truncated toward zero.
    always_comb begin
        logic signed [64:0] d;
        logic signed [64:0] q;
        for (int c = 0; c < 3; c++) begin
            d = 65'(r_cp[2 * c]) - 65'(r_cp[2 * c + 1]);
            q = d >>> psit_pkg::FRAC_BITS;
            if (d[64] && (d[psit_pkg::FRAC_BITS - 1:0] != '0)) begin
                q = q + 65'sd1;
            end
            n_cr[c] = q[32:0];
        end
    end

    always_comb begin
        dot_sum = 66'(r_dp[0]) + 66'(r_dp[1]) + 66'(r_dp[2])
                  + (66'(i_eps) <<< psit_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u.x <= 33'(i_s.x) - 33'(i_p.x);
            r_u.y <= 33'(i_s.y) - 33'(i_p.y);
            r_u.z <= 33'(i_s.z) - 33'(i_p.z);
            r_v.x <= 33'(i_f.x) - 33'(i_p.x);
            r_v.y <= 33'(i_f.y) - 33'(i_p.y);
            r_v.z <= 33'(i_f.z) - 33'(i_p.z);

            r_fd[0] <= i_f;
            for (int i = 1; i < psit_pkg::F_DLY; i++) begin
                r_fd[i] <= r_fd[i - 1];
            end

            r_cp[0] <= 64'(nu.y) * 64'(nv.z);
            r_cp[1] <= 64'(nu.z) * 64'(nv.y);
            r_cp[2] <= 64'(nu.z) * 64'(nv.x);
            r_cp[3] <= 64'(nu.x) * 64'(nv.z);
            r_cp[4] <= 64'(nu.x) * 64'(nv.y);
            r_cp[5] <= 64'(nu.y) * 64'(nv.x);

            r_n.x <= n_cr[0];
            r_n.y <= n_cr[1];
            r_n.z <= n_cr[2];

            r_dp[0] <= 64'(nn.x) * 64'(r_fd[psit_pkg::F_DLY - 1].x);
            r_dp[1] <= 64'(nn.y) * 64'(r_fd[psit_pkg::F_DLY - 1].y);
            r_dp[2] <= 64'(nn.z) * 64'(r_fd[psit_pkg::F_DLY - 1].z);

            r_pass <= !dot_sum[65];
        end
    end

    assign o_pass = r_pass;

endmodule

/* src/point_in_spherical_triangle_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// i_in      in   valid / ready    a_x..p_z, signed Q1.30, 32 bits each
// o_out     out  valid / ready    inside_res, edge_pass[2:0]
// i_cfg_*   in   i_cfg_we only    index 0 side_epsilon, index 1 norm_tolerance
//
// One transaction is accepted per cycle unless the output is stalled; the depth
// of each result's path is set by the two chained normalizers of an edge
// (square, 33 root stages, 31 divide stages each).
// The whole pipeline advances together; every stage holds while the output is
// full and not taken, and otherwise all stages move on, empty slots included.
// Reset clears the valid bits and restores both registers.

module point_in_spherical_triangle_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psit_in_if.sink     i_in,
    psit_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_wdata
);

    localparam int LAST = psit_pkg::EDGE_LAT - 1;

    logic signed [30:0]        r_eps;
    logic [29:0]               r_tol;
    logic [LAST:0]             r_vld;
    logic                      adv;
    logic [2:0]                pass;
    psit_pkg::t_vec32          va;
    psit_pkg::t_vec32          vb;
    psit_pkg::t_vec32          vc;
    psit_pkg::t_vec32          vp;

    assign adv = !r_vld[LAST] || o_out.ready;
    assign i_in.ready = adv;

    assign va = '{x: i_in.a_x, y: i_in.a_y, z: i_in.a_z};
    assign vb = '{x: i_in.b_x, y: i_in.b_y, z: i_in.b_z};
    assign vc = '{x: i_in.c_x, y: i_in.c_y, z: i_in.c_z};
    assign vp = '{x: i_in.p_x, y: i_in.p_y, z: i_in.p_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
            r_tol <= psit_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            case (psit_pkg::t_cfg_idx'(i_cfg_idx))
                psit_pkg::CFG_EPS: r_eps <= i_cfg_wdata;
                psit_pkg::CFG_TOL: r_tol <= i_cfg_wdata[29:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAST - 1:0], i_in.valid};
        end
    end

    psit_edge u_edge_ab (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_eps  (r_eps),
        .i_tol  (r_tol),
        .i_f    (va),
        .i_s    (vb),
        .i_p    (vp),
        .o_pass (pass[0])
    );

    psit_edge u_edge_bc (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_eps  (r_eps),
        .i_tol  (r_tol),
        .i_f    (vb),
        .i_s    (vc),
        .i_p    (vp),
        .o_pass (pass[1])
    );

    psit_edge u_edge_ca (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_eps  (r_eps),
        .i_tol  (r_tol),
        .i_f    (vc),
        .i_s    (va),
        .i_p    (vp),
        .o_pass (pass[2])
    );

    assign o_out.valid      = r_vld[LAST];
    assign o_out.edge_pass  = pass;
    assign o_out.inside_res = &pass;

`ifndef ASSERT_OFF
    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_inside_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.inside_res == (&o_out.edge_pass)))
        else $error("inside flag disagrees with edge flags");
`endif

endmodule
